// ----- rtl/core/alu8_pkg.sv -----
package alu8_pkg;

  // Operation codes
  typedef enum logic [3:0] {
    OpAdc  = 4'd0,
    OpSbc  = 4'd1,
    OpAnd  = 4'd2,
    OpOr   = 4'd3,
    OpXor  = 4'd4,
    OpCmp  = 4'd5,
    OpBit  = 4'd6,
    OpAsl  = 4'd7,
    OpLsr  = 4'd8,
    OpRol  = 4'd9,
    OpRor  = 4'd10,
    OpInc  = 4'd11,
    OpDec  = 4'd12,
    OpPass = 4'd13
  } alu8_op_e;

  // Status bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  // Largest valid decimal digit
  localparam logic [5:0] BcdDigitMax = 6'd9;
  localparam logic [5:0] BcdAdjust   = 6'd6;
  localparam logic [9:0] BcdHiAdjust = 10'h060;

  typedef struct packed {
    logic [3:0] operation;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [7:0] status_in;
  } alu8_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] status_out;
  } alu8_out_t;

  // Update N and Z from a result byte
  function automatic logic [7:0] set_nz(logic [7:0] st, logic [7:0] v);
    logic [7:0] s;
    s        = st;
    s[FlagZ] = (v == 8'h00);
    s[FlagN] = v[7];
    return s;
  endfunction

endpackage

// ----- rtl/core/alu8_addsub.sv -----
module alu8_addsub (
  input  logic       sub_i,
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  input  logic [7:0] st_i,
  output logic [7:0] res_o,
  output logic [7:0] st_o
);
  import alu8_pkg::*;

  // Adder and subtractor with carry, binary or packed BCD
  always_comb begin
    logic [8:0] sum;
    logic [7:0] bin;
    logic [7:0] mid;
    logic [5:0] lo;
    logic [5:0] hi;
    logic [5:0] dlo;
    logic [9:0] hv;
    logic       cin;
    logic [7:0] s;
    logic [7:0] bx;

    cin = st_i[FlagC];
    s   = st_i;
    bx  = sub_i ? ~b_i : b_i;
    sum = {1'b0, a_i} + {1'b0, bx} + {8'd0, cin};
    bin = sum[7:0];
    res_o = bin;

    // Binary flags, kept for subtract in either mode
    s[FlagC] = sum[8];
    s[FlagV] = (a_i[7] ~^ bx[7]) & (a_i[7] ^ bin[7]);
    s        = set_nz(s, bin);

    lo  = '0;
    hi  = '0;
    mid = '0;
    dlo = '0;
    hv  = '0;

    if (st_i[FlagD]) begin
      if (!sub_i) begin
        // Decimal add: N and V from the sum before the high digit adjust
        lo = {2'b00, a_i[3:0]} + {2'b00, b_i[3:0]} + {5'd0, cin};
        if (lo > BcdDigitMax) lo = lo + BcdAdjust;
        hi = {2'b00, a_i[7:4]} + {2'b00, b_i[7:4]} + {5'd0, (lo > 6'd15)};
        mid = {hi[3:0], lo[3:0]};
        s[FlagN] = mid[7];
        s[FlagV] = (a_i[7] ~^ b_i[7]) & (a_i[7] ^ mid[7]);
        if (hi > BcdDigitMax) hi = hi + BcdAdjust;
        s[FlagC] = (hi > 6'd15);
        res_o = {hi[3:0], lo[3:0]};
      end else begin
        // Decimal subtract: each borrowing digit corrected by six
        dlo = {2'b00, a_i[3:0]} - {2'b00, b_i[3:0]} - {5'd0, ~cin};
        if (dlo[5]) dlo = {2'b11, dlo[3:0] + 4'd10};
        hv = {2'b00, a_i[7:4], 4'd0} - {2'b00, b_i[7:4], 4'd0} + {{4{dlo[5]}}, dlo};
        if (hv[9]) hv = hv - BcdHiAdjust;
        res_o = hv[7:0];
      end
    end
    st_o = s;
  end

endmodule

// ----- rtl/core/alu8_core.sv -----
module alu8_core (
  input  alu8_pkg::alu8_in_t  in_i,
  output alu8_pkg::alu8_out_t out_o
);
  import alu8_pkg::*;

  logic [7:0] as_res;
  logic [7:0] as_st;

  alu8_addsub u_addsub (
    .sub_i (in_i.operation == OpSbc),
    .a_i   (in_i.operand_a),
    .b_i   (in_i.operand_b),
    .st_i  (in_i.status_in),
    .res_o (as_res),
    .st_o  (as_st)
  );

  // Operation select and flag update
  always_comb begin
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] st;
    logic [7:0] r;
    logic [7:0] s;
    logic [8:0] diff;

    a    = in_i.operand_a;
    b    = in_i.operand_b;
    st   = in_i.status_in;
    r    = a;
    s    = st;
    diff = {1'b0, a} + {1'b0, ~b} + 9'd1;

    case (alu8_op_e'(in_i.operation))
      OpAdc, OpSbc: begin
        r = as_res;
        s = as_st;
      end
      OpAnd: begin r = a & b; s = set_nz(st, r); end
      OpOr:  begin r = a | b; s = set_nz(st, r); end
      OpXor: begin r = a ^ b; s = set_nz(st, r); end
      OpCmp: begin
        s        = set_nz(st, diff[7:0]);
        s[FlagC] = diff[8];
      end
      OpBit: begin
        s[FlagN] = b[7];
        s[FlagV] = b[6];
        s[FlagZ] = ((a & b) == 8'h00);
      end
      OpAsl: begin
        r = {b[6:0], 1'b0};
        s[FlagC] = b[7];
        s = set_nz(s, r);
      end
      OpLsr: begin
        r = {1'b0, b[7:1]};
        s[FlagC] = b[0];
        s = set_nz(s, r);
      end
      OpRol: begin
        r = {b[6:0], st[FlagC]};
        s[FlagC] = b[7];
        s = set_nz(s, r);
      end
      OpRor: begin
        r = {st[FlagC], b[7:1]};
        s[FlagC] = b[0];
        s = set_nz(s, r);
      end
      OpInc:  begin r = b + 8'd1; s = set_nz(st, r); end
      OpDec:  begin r = b - 8'd1; s = set_nz(st, r); end
      OpPass: begin r = b; s = set_nz(st, r); end
      default: begin
        r = a;
        s = st;
      end
    endcase

    out_o.result     = r;
    out_o.status_out = s;
  end

endmodule

// ----- rtl/core/cpu8_alu_status_unit_top.sv -----
// Channel   Handshake              Word
// -------   --------------------   ---------------------------------------
// command   start_i / busy_o       in_word_i  (operation, operands, status)
// result    done_o (strobe)        out_word_o (result byte, new status)
//
// One word accepted per cycle; busy_o stays low, so start_i may be held high.
// A word passes the input register, then the result register after the ALU.
// done_o is high for exactly one cycle per accepted word, in accept order.
// Reset clears the valid flags only; the receiver cannot stall the unit.
module cpu8_alu_status_unit_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  alu8_pkg::alu8_in_t  in_word_i,
  output logic                done_o,
  output alu8_pkg::alu8_out_t out_word_o
);
  import alu8_pkg::*;

  logic      in_vld_q;
  alu8_in_t  in_q;
  logic      out_vld_q;
  alu8_out_t out_q;
  alu8_out_t out_d;
  logic      accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
  end

  alu8_core u_core (
    .in_i  (in_q),
    .out_o (out_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      out_q <= out_d;
    end
  end

  assign done_o     = out_vld_q;
  assign out_word_o = out_q;

  // Every accepted word yields a strobe after the input and result registers
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted word produced no result strobe");

  // No strobe without a word in the input register the cycle before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_vld_q))
    else $error("result strobe without a word in flight");

  // Decimal mode bit is never altered
  a_dflag_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |=> out_q.status_out[FlagD] == $past(in_q.status_in[FlagD]))
    else $error("decimal flag changed");

  // Compare and bit test return the first operand
  a_cmp_bit_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && (in_q.operation == OpCmp || in_q.operation == OpBit))
      |=> out_q.result == $past(in_q.operand_a))
    else $error("compare or bit test altered the result byte");

endmodule
